FILE: hw/rtl/sha1s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared word types, hash constants and sizing for the hasher modules.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] state_words_t;

  // Control from the sequencer to the message schedule window
  typedef struct packed {
    logic load;    // shift a freshly packed message word in
    logic expand;  // advance one round, appending an expanded word
  } sched_ctl_t;

  localparam word_t K_ROUND_0 = 32'h5A827999;
  localparam word_t K_ROUND_1 = 32'h6ED9EBA1;
  localparam word_t K_ROUND_2 = 32'h8F1BBCDC;
  localparam word_t K_ROUND_3 = 32'hCA62C1D6;

  localparam state_words_t H_INIT = '{
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  function automatic word_t rotl(input word_t x, input int unsigned s);
    rotl = (x << s) | (x >> (32 - s));
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sha1_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-serial SHA-1 with a single shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one message byte (data_byte, qualified by has_byte)
//   and an is_last flag that closes the message. in_ready is high only while
//   the sequencer is idle. A byte that does not complete a 64-byte block
//   leaves the sequencer idle. The 64th byte of a block starts the
//   compression: the round unit runs all 80 rounds, one round a cycle,
//   then the chaining add follows in S_FINAL. A last request adds padding
//   one byte a cycle through the same path, one or two compressions, and
//   a load of the digest register in S_DONE, which waits while the
//   receiver stalls with the previous digest still unread.
//   The digest sits in an output register: while the receiver stalls
//   the next message is taken, and only a further digest waits for it.
//   Reset (rst, synchronous) loads the initial chaining values, clears the
//   byte and bit counts and drops out_valid; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  data_byte,
  input  wire        has_byte,
  input  wire        is_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [63:0] digest_high,
  output logic [63:0] digest_middle,
  output logic [31:0] digest_low
);
  import sha1s_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FINAL,
    S_DONE
  } state_t;

  state_t       state;
  state_words_t chain;
  state_words_t work;
  state_words_t work_next;
  logic [5:0]   fill;
  logic [23:0]  acc;
  logic [63:0]  msg_bits;
  logic [6:0]   round;
  logic         pad_mode;
  logic         marker_sent;
  logic         len_ok;

  logic         push_en;
  logic [7:0]   push_val;
  logic [7:0]   len_byte;
  logic         block_full;
  sched_ctl_t   sched_ctl;
  word_t        w_cur;

  assign in_ready = (state == S_IDLE);

  // Length bytes, most significant first, at positions 56 to 63
  assign len_byte = msg_bits[{~fill[2:0], 3'b000} +: 8];

  // Byte source: message bytes when idle, padding bytes while padding
  always_comb begin
    push_en  = 1'b0;
    push_val = data_byte;
    if (state == S_IDLE && in_valid && has_byte) begin
      push_en = 1'b1;
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (!marker_sent) begin
        push_val = PAD_MARKER;
      end else if (len_ok && fill >= LEN_POS) begin
        push_val = len_byte;
      end else begin
        push_val = 8'h00;
      end
    end
  end

  assign block_full       = push_en && (fill == BLOCK_LAST);
  assign sched_ctl.load   = push_en && (fill[1:0] == 2'b11);
  assign sched_ctl.expand = (state == S_COMP);

  sha1s_sched u_sched (
    .clk     (clk),
    .ctl     (sched_ctl),
    .word_in ({acc, push_val}),
    .w_cur   (w_cur)
  );

  sha1s_round u_round (
    .work_in  (work),
    .w_cur    (w_cur),
    .round    (round),
    .work_out (work_next)
  );

  // Sequencer, counters, chaining words and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chain       <= H_INIT;
      fill        <= '0;
      msg_bits    <= '0;
      round       <= '0;
      pad_mode    <= 1'b0;
      marker_sent <= 1'b0;
      len_ok      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      // Byte packing into words; count wraps at the block end
      if (push_en) begin
        acc  <= {acc[15:0], push_val};
        fill <= fill + 6'd1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pad_mode <= is_last;
            if (has_byte) begin
              msg_bits <= msg_bits + 64'd8;
            end
            if (block_full) begin
              work  <= chain;
              round <= '0;
              state <= S_COMP;
            end else if (is_last) begin
              state <= S_PAD;
            end
          end
        end

        S_PAD: begin
          if (!marker_sent) begin
            marker_sent <= 1'b1;
            // room for the length in this block
            if (fill < LEN_POS) begin
              len_ok <= 1'b1;
            end
          end
          if (block_full) begin
            work  <= chain;
            round <= '0;
            state <= S_COMP;
          end
        end

        S_COMP: begin
          work  <= work_next;
          round <= round + 7'd1;
          if (round == ROUND_LAST) begin
            state <= S_FINAL;
          end
        end

        S_FINAL: begin
          for (int i = 0; i < 5; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (pad_mode && len_ok) begin
            state <= S_DONE;
          end else if (pad_mode) begin
            // marker block done; length goes in a block of its own
            len_ok <= 1'b1;
            state  <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            digest_high   <= {chain[0], chain[1]};
            digest_middle <= {chain[2], chain[3]};
            digest_low    <= chain[4];
            out_valid     <= 1'b1;
            chain         <= H_INIT;
            fill          <= '0;
            msg_bits      <= '0;
            pad_mode      <= 1'b0;
            marker_sent   <= 1'b0;
            len_ok        <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sha1s_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message schedule window
// Sixteen-word shift line; filled with block words, then expanded in place.
// ----------------------------------------------------------------------------
module sha1s_sched (
  input  wire                   clk,
  input  sha1s_pkg::sched_ctl_t ctl,
  input  sha1s_pkg::word_t      word_in,
  output sha1s_pkg::word_t      w_cur
);
  import sha1s_pkg::*;

  word_t win [16];
  word_t expanded;

  // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
  assign expanded = rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);
  assign w_cur    = win[0];

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.expand) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= ctl.load ? word_in : expanded;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sha1s_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round, reused for all eighty rounds of a block.
// ----------------------------------------------------------------------------
module sha1s_round (
  input  sha1s_pkg::state_words_t work_in,
  input  sha1s_pkg::word_t        w_cur,
  input  wire [6:0]               round,
  output sha1s_pkg::state_words_t work_out
);
  import sha1s_pkg::*;

  word_t a, b, c, d, e;
  word_t fn, kc;

  assign a = work_in[0];
  assign b = work_in[1];
  assign c = work_in[2];
  assign d = work_in[3];
  assign e = work_in[4];

  // Round function and constant by round group
  always_comb begin
    if (round < 7'd20) begin
      fn = (b & c) | (~b & d);
      kc = K_ROUND_0;
    end else if (round < 7'd40) begin
      fn = b ^ c ^ d;
      kc = K_ROUND_1;
    end else if (round < 7'd60) begin
      fn = (b & c) | (b & d) | (c & d);
      kc = K_ROUND_2;
    end else begin
      fn = b ^ c ^ d;
      kc = K_ROUND_3;
    end
  end

  assign work_out[0] = rotl(a, 5) + fn + e + kc + w_cur;
  assign work_out[1] = a;
  assign work_out[2] = rotl(b, 30);
  assign work_out[3] = c;
  assign work_out[4] = d;

endmodule
`default_nettype wire

FILE: tb/sv/sha1_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Sends byte-serial messages through the hasher under random gaps on both
// handshakes. A local SHA-1 model, updated on every accepted request,
// queues the digest that each closing request should produce. Every digest
// that the block delivers is checked field by field against that queue.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;

  // SHA-1 initial chaining values and round constants
  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_2 = 32'h98BADCFE;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
  localparam logic [31:0] RC_0 = 32'h5A827999;
  localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC_3 = 32'hCA62C1D6;
  localparam logic [7:0]  END_MARK  = 8'h80;
  localparam int          LEN_SLOT  = 56;
  localparam int          BLK_BYTES = 64;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          MIN_DIGESTS  = 20;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
    int         gap;    // idle cycles before this request
    bit         drain;  // hold off until every digest is back
  } byte_req_t;

  typedef struct {
    logic [63:0] high;
    logic [63:0] middle;
    logic [31:0] low;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_high;
  logic [63:0] digest_middle;
  logic [31:0] digest_low;

  // Local hash state
  logic [31:0] hash_words [5];
  logic [7:0]  block_buf [BLK_BYTES];
  logic [5:0]  fill_level;
  logic [63:0] bit_total;

  byte_req_t byte_reqs [$];
  digest_t   pending_digests [$];
  digest_t   want;
  byte_req_t cur_req;
  int        error_count = 0;
  int        stim_items = 0;
  int        gap_left = 0;
  int        ready_left = 0;
  bit        req_taken = 1'b0;

  sha1_stream_hasher u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .has_byte      (has_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_high   (digest_high),
    .digest_middle (digest_middle),
    .digest_low    (digest_low)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  task automatic clear_hash_state();
    hash_words[0] = IV_0;
    hash_words[1] = IV_1;
    hash_words[2] = IV_2;
    hash_words[3] = IV_3;
    hash_words[4] = IV_4;
    fill_level = '0;
    bit_total = '0;
  endtask

  // One 80-round compression of block_buf into hash_words
  task automatic compress_buf();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rot_left(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_2;
      end else begin
        f = b ^ c ^ d;
        k = RC_3;
      end
      t = rot_left(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rot_left(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endtask

  // Absorb one accepted request; a closing request pads and queues a digest
  task automatic sha1_absorb(input logic [7:0] d, input logic hb, input logic last);
    int pos;
    digest_t dg;
    if (hb) begin
      block_buf[fill_level] = d;
      bit_total += 64'd8;
      fill_level += 6'd1;
      if (fill_level == 6'd0) compress_buf();
    end
    if (!last) return;
    block_buf[fill_level] = END_MARK;
    pos = int'(fill_level) + 1;
    // no room left for the length: zero-fill, compress, start a fresh block
    if (pos > LEN_SLOT) begin
      while (pos < BLK_BYTES) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      compress_buf();
      pos = 0;
    end
    while (pos < LEN_SLOT) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++)
      block_buf[LEN_SLOT + i] = bit_total[63 - 8*i -: 8];
    compress_buf();
    dg.high   = {hash_words[0], hash_words[1]};
    dg.middle = {hash_words[2], hash_words[3]};
    dg.low    = hash_words[4];
    pending_digests.push_back(dg);
    clear_hash_state();
  endtask

  task automatic add_req(input logic [7:0] d, input logic hb, input logic last,
                         input bit quiet, input bit drain);
    byte_req_t q;
    q.data  = d;
    q.has   = hb;
    q.last  = last;
    q.gap   = pick_gap(quiet);
    q.drain = drain;
    byte_reqs.push_back(q);
    if (hb || last) stim_items++;
  endtask

  // A message of len bytes, closed either on its final byte or by a bare last
  task automatic queue_message(input int len, input bit quiet, input bit byte_on_last,
                               input bit drain);
    bit close_on_byte;
    close_on_byte = byte_on_last && (len > 0);
    for (int i = 0; i < len; i++) begin
      if (!quiet && $urandom_range(0, 24) == 0)
        add_req(8'($urandom), 1'b0, 1'b0, quiet, 1'b0);
      add_req(8'($urandom), 1'b1, close_on_byte && (i == len - 1), quiet,
              drain && (i == 0));
    end
    if (!close_on_byte)
      add_req(8'($urandom), 1'b0, 1'b1, quiet, drain && (len == 0));
  endtask

  // Driver: presents requests at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (byte_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_reqs[0].drain && pending_digests.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_req = byte_reqs.pop_front();
        in_valid  <= 1'b1;
        data_byte <= cur_req.data;
        has_byte  <= cur_req.has;
        is_last   <= cur_req.last;
        gap_left = (byte_reqs.size() != 0) ? byte_reqs[0].gap : 0;
      end
    end
  end

  // Receiver: random stalls on out_ready, with the odd long open stretch
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready) begin
      ready_left = pick_gap(1'b0);
      if (ready_left > 0) begin
        out_ready <= 1'b0;
        ready_left--;
      end else begin
        ready_left = $urandom_range(0, 20);
      end
    end else begin
      out_ready <= 1'b1;
      ready_left = ($urandom_range(0, 24) == 0) ? 600 : $urandom_range(0, 40);
    end
  end

  // Monitor: checks delivered digests, then feeds accepted requests to the model
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          $display("%0t: digest with none expected: %h %h %h", $time,
                   digest_high, digest_middle, digest_low);
          error_count++;
        end else begin
          want = pending_digests.pop_front();
          if (digest_high !== want.high) begin
            $display("%0t: digest_high expected %h actual %h", $time, want.high,
                     digest_high);
            error_count++;
          end
          if (digest_middle !== want.middle) begin
            $display("%0t: digest_middle expected %h actual %h", $time, want.middle,
                     digest_middle);
            error_count++;
          end
          if (digest_low !== want.low) begin
            $display("%0t: digest_low expected %h actual %h", $time, want.low,
                     digest_low);
            error_count++;
          end
        end
      end
      req_taken = in_valid && in_ready;
      if (req_taken) sha1_absorb(data_byte, has_byte, is_last);
    end
  end

  // Stimulus and end of run
  initial begin
    int len;
    int r;
    int n_msgs;
    int boundary_lens [13] = '{54, 55, 56, 57, 62, 63, 64, 65, 118, 119, 120, 127, 128};
    clear_hash_state();
    for (int i = 0; i < BLK_BYTES; i++) block_buf[i] = 8'h00;

    // Directed: empty message, "abc" with a stray request inside, byte extremes
    queue_message(0, 1'b0, 1'b0, 1'b0);
    add_req(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_req(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);

    // Random messages; lengths lean towards the padding boundaries
    n_msgs = 0;
    stim_items = 0;
    while (stim_items < RANDOM_ITEMS || n_msgs < MIN_DIGESTS) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        len = $urandom_range(0, 16);
      else if (r < 80)
        len = boundary_lens[$urandom_range(0, 12)];
      else
        len = $urandom_range(17, 100);
      queue_message(len, $urandom_range(0, 4) == 0, $urandom_range(0, 1) == 1,
                    (n_msgs == 0) || ($urandom_range(0, 11) == 0));
      n_msgs++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_reqs.size() != 0 || in_valid) @(posedge clk);
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
